// File: hdl/hrf_pkg.sv
`timescale 1ns / 1ps

package hrf_pkg;

   // Result status codes
   localparam logic [1:0] STATUS_MORE = 2'd0;
   localparam logic [1:0] STATUS_DONE = 2'd1;
   localparam logic [1:0] STATUS_LONG = 2'd2;

   // Characters the framer reacts to
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // Length of the "content-length:" prefix
   localparam logic [3:0] PREFIX_LEN = 4'd15;

   // Saturation value of the body length
   localparam logic [30:0] LENGTH_MAX = 31'h7FFF_FFFF;

   // Header field scan phases
   typedef enum logic [3:0] {
      PH_PREFIX = 4'b0001,
      PH_SPACES = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_IGNORE = 4'b1000
   } field_phase_type;

   // Control from the frame logic to the field scanner
   typedef struct packed {
      logic clear;      // request finished, back to reset values
      logic line_end;   // non-empty header line closed
      logic scan_byte;  // byte belongs to a header line after the first
   } scan_ctl_type;

   // Lower-case form of the field name prefix
   function automatic logic [7:0] prefix_char(input logic [3:0] pos);
      logic [7:0] c;
      unique case (pos)
         4'd0:    c = 8'h63; // c
         4'd1:    c = 8'h6F; // o
         4'd2:    c = 8'h6E; // n
         4'd3:    c = 8'h74; // t
         4'd4:    c = 8'h65; // e
         4'd5:    c = 8'h6E; // n
         4'd6:    c = 8'h74; // t
         4'd7:    c = 8'h2D; // -
         4'd8:    c = 8'h6C; // l
         4'd9:    c = 8'h65; // e
         4'd10:   c = 8'h6E; // n
         4'd11:   c = 8'h67; // g
         4'd12:   c = 8'h74; // t
         4'd13:   c = 8'h68; // h
         4'd14:   c = 8'h3A; // :
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   // Map upper-case letters to lower case
   function automatic logic [7:0] fold_case(input logic [7:0] b);
      logic [7:0] r;
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         r = b + CASE_OFFSET;
      end else begin
         r = b;
      end
      return r;
   endfunction

endpackage

// File: hdl/hrf_field_scan.sv
`timescale 1ns / 1ps

module hrf_field_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  hrf_pkg::scan_ctl_type scan_ctl,
   input  logic [7:0]           data_byte,
   output logic [30:0]          body_length
);
   import hrf_pkg::*;

   field_phase_type phase_ff, phase_in;
   logic [3:0]      match_pos_ff, match_pos_in;
   logic [30:0]     body_length_ff, body_length_in;

   logic            is_digit;
   logic [34:0]     times_ten;
   logic [34:0]     accum;
   logic [30:0]     accum_sat;

   assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);

   // Multiply by ten with shifts, add the digit, saturate
   assign times_ten = {1'b0, body_length_ff, 3'b000} + {3'b000, body_length_ff, 1'b0};
   assign accum     = times_ten + {31'd0, data_byte[3:0] - CHAR_ZERO[3:0]};
   assign accum_sat = (accum[34:31] != 4'd0) ? LENGTH_MAX : accum[30:0];

   // Advance the prefix match and digit accumulation
   always_comb begin
      phase_in       = phase_ff;
      match_pos_in   = match_pos_ff;
      body_length_in = body_length_ff;
      if (step) begin
         priority if (scan_ctl.clear) begin
            phase_in       = PH_PREFIX;
            match_pos_in   = 4'd0;
            body_length_in = 31'd0;
         end else if (scan_ctl.line_end) begin
            phase_in     = PH_PREFIX;
            match_pos_in = 4'd0;
         end else if (scan_ctl.scan_byte) begin
            unique case (phase_ff)
               PH_PREFIX: begin
                  if (fold_case(data_byte) == prefix_char(match_pos_ff)) begin
                     match_pos_in = match_pos_ff + 4'd1;
                     if (match_pos_ff + 4'd1 == PREFIX_LEN) begin
                        phase_in       = PH_SPACES;
                        body_length_in = 31'd0;
                     end
                  end else begin
                     phase_in = PH_IGNORE;
                  end
               end
               PH_SPACES: begin
                  priority if (data_byte == CHAR_SPACE) begin
                     phase_in = PH_SPACES;
                  end else if (is_digit) begin
                     phase_in       = PH_DIGITS;
                     body_length_in = accum_sat;
                  end else begin
                     phase_in = PH_IGNORE;
                  end
               end
               PH_DIGITS: begin
                  if (is_digit) begin
                     body_length_in = accum_sat;
                  end else begin
                     phase_in = PH_IGNORE;
                  end
               end
               PH_IGNORE: begin
                  phase_in = PH_IGNORE;
               end
               default: begin
                  phase_in = PH_IGNORE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_PREFIX;
         match_pos_ff   <= 4'd0;
         body_length_ff <= 31'd0;
      end else begin
         phase_ff       <= phase_in;
         match_pos_ff   <= match_pos_in;
         body_length_ff <= body_length_in;
      end
   end

   assign body_length = body_length_ff;

endmodule

// File: hdl/http_request_framer.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                                   Transfer when
// req       in         req_valid, req_stall, req_data_byte     req_valid && !req_stall
// rsp       out        rsp_valid, rsp_stall, rsp_status,       rsp_valid && !rsp_stall
//                      rsp_request_length, rsp_header_length,
//                      rsp_content_length
// csr       in         csr_write_enable, csr_write_data        csr_write_enable
//
// One byte per cycle sustained while rsp_stall is low; each byte gives one result.
// The byte passes an input register, one pass of frame and field logic, and a result register.
// Reset is synchronous; it clears the request state and sets header_limit to 4095.
// A stalled result holds the result register; the input register still takes one byte,
// and req_stall rises only when both registers are full.

module http_request_framer #(
   parameter int HEADER_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_request_length,
   output logic [11:0] rsp_header_length,
   output logic [30:0] rsp_content_length,
   input  logic        csr_write_enable,
   input  logic [11:0] csr_write_data
);
   import hrf_pkg::*;

   localparam logic [31:0] LIMIT_CAP = 32'(HEADER_BYTES - 1);

   // Configuration
   logic [11:0] header_limit_ff;

   // Input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;

   // Request state
   logic        in_body_ff, in_body_in;
   logic [31:0] byte_count_ff, byte_count_in;
   logic [1:0]  line_bytes_ff, line_bytes_in;
   logic        last_cr_ff, last_cr_in;
   logic        first_line_ff, first_line_in;
   logic        blocked_ff, blocked_in;
   logic [11:0] header_bytes_ff, header_bytes_in;
   logic [31:0] target_ff, target_in;

   // Result register
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] req_len_ff, req_len_in;
   logic [11:0] hdr_len_ff, hdr_len_in;
   logic [30:0] body_len_ff, body_len_in;

   logic         accept;
   logic         fire;
   logic [31:0]  count_next;
   logic [31:0]  limit_full;
   logic [31:0]  limit_use;
   logic         line_empty;
   logic         done;
   logic         too_long;
   logic [30:0]  body_length;
   scan_ctl_type scan_ctl;

   // Handshake: process when the result register is free or draining
   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   assign limit_full = {20'd0, header_limit_ff};
   assign limit_use  = (limit_full > LIMIT_CAP) ? LIMIT_CAP : limit_full;
   assign count_next = byte_count_ff + 32'd1;
   assign line_empty = (line_bytes_ff == 2'd0) || ((line_bytes_ff == 2'd1) && last_cr_ff);

   // Frame one byte: line tracking, header end, body count, limit check
   always_comb begin
      in_body_in      = in_body_ff;
      byte_count_in   = count_next;
      line_bytes_in   = line_bytes_ff;
      last_cr_in      = last_cr_ff;
      first_line_in   = first_line_ff;
      blocked_in      = blocked_ff;
      header_bytes_in = header_bytes_ff;
      target_in       = target_ff;
      done            = 1'b0;
      too_long        = 1'b0;
      scan_ctl        = '0;
      hdr_len_in      = 12'd0;

      if (in_body_ff) begin
         done       = (count_next == target_ff);
         hdr_len_in = header_bytes_ff;
      end else begin
         priority if (blocked_ff) begin
            blocked_in = 1'b1;
         end else if (in_byte_ff == CHAR_NUL) begin
            blocked_in = 1'b1;
         end else if (in_byte_ff == CHAR_LF) begin
            if (line_empty) begin
               header_bytes_in = count_next[11:0];
               hdr_len_in      = count_next[11:0];
               if (body_length == 31'd0) begin
                  done = 1'b1;
               end else begin
                  in_body_in = 1'b1;
                  target_in  = {20'd0, count_next[11:0]} + {1'b0, body_length};
               end
            end else begin
               first_line_in     = 1'b0;
               line_bytes_in     = 2'd0;
               last_cr_in        = 1'b0;
               scan_ctl.line_end = 1'b1;
            end
         end else begin
            scan_ctl.scan_byte = !first_line_ff;
            line_bytes_in      = (line_bytes_ff == 2'd2) ? 2'd2 : line_bytes_ff + 2'd1;
            last_cr_in         = (in_byte_ff == CHAR_CR);
         end
         too_long = !done && !in_body_in && (count_next >= limit_use);
      end

      // Drop the request state, all but the body target, once a request finishes or runs too long
      scan_ctl.clear = done || too_long;
      if (done || too_long) begin
         in_body_in      = 1'b0;
         byte_count_in   = 32'd0;
         line_bytes_in   = 2'd0;
         last_cr_in      = 1'b0;
         first_line_in   = 1'b1;
         blocked_in      = 1'b0;
         header_bytes_in = 12'd0;
      end
   end

   // Result fields
   always_comb begin
      priority if (done) begin
         status_in   = STATUS_DONE;
         req_len_in  = count_next;
         body_len_in = body_length;
      end else if (too_long) begin
         status_in   = STATUS_LONG;
         req_len_in  = 32'd0;
         body_len_in = 31'd0;
      end else begin
         status_in   = STATUS_MORE;
         req_len_in  = 32'd0;
         body_len_in = 31'd0;
      end
   end

   assign in_valid_in  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (out_valid_ff && rsp_stall);

   hrf_field_scan u_field_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (fire),
      .scan_ctl    (scan_ctl),
      .data_byte   (in_byte_ff),
      .body_length (body_length)
   );

   // Hold the header limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         header_limit_ff <= 12'd4095;
      end else if (csr_write_enable) begin
         header_limit_ff <= csr_write_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_byte_ff <= req_data_byte;
      end
   end

   // Advance request state on each processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff      <= 1'b0;
         byte_count_ff   <= 32'd0;
         line_bytes_ff   <= 2'd0;
         last_cr_ff      <= 1'b0;
         first_line_ff   <= 1'b1;
         blocked_ff      <= 1'b0;
         header_bytes_ff <= 12'd0;
      end else if (fire) begin
         in_body_ff      <= in_body_in;
         byte_count_ff   <= byte_count_in;
         line_bytes_ff   <= line_bytes_in;
         last_cr_ff      <= last_cr_in;
         first_line_ff   <= first_line_in;
         blocked_ff      <= blocked_in;
         header_bytes_ff <= header_bytes_in;
      end
      if (fire) begin
         target_ff <= target_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (fire) begin
         status_ff   <= status_in;
         req_len_ff  <= req_len_in;
         hdr_len_ff  <= (status_in == STATUS_DONE) ? hdr_len_in : 12'd0;
         body_len_ff <= body_len_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_request_length = req_len_ff;
   assign rsp_header_length  = hdr_len_ff;
   assign rsp_content_length = body_len_ff;

endmodule

// File: hdl/hrf_checker.sv
`timescale 1ns / 1ps

module hrf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_request_length,
   input logic [11:0] rsp_header_length,
   input logic [30:0] rsp_content_length
);
   import hrf_pkg::*;

   // Lengths are reported only with a complete request
   a_zero_unless_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_DONE) |->
         (rsp_request_length == 32'd0) && (rsp_header_length == 12'd0) &&
         (rsp_content_length == 31'd0))
      else $error("lengths reported without a complete request");

   // A complete request is header plus body
   a_length_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_DONE) |->
         rsp_request_length == ({20'd0, rsp_header_length} + {1'b0, rsp_content_length}))
      else $error("request length differs from header plus body");

   // A complete request has at least its terminating line
   a_header_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_DONE) |-> rsp_header_length != 12'd0)
      else $error("complete request with empty header");

   // A stalled result transfer holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_request_length))
      else $error("stalled result changed");

endmodule

bind http_request_framer hrf_checker u_hrf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_request_length (rsp_request_length),
   .rsp_header_length  (rsp_header_length),
   .rsp_content_length (rsp_content_length)
);
